// ===== rtl/integral_image_area_sum_defines.svh =====
// ----------------------------------------------------------------------------
// Integral image area sum: assertion macros
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGRAL_IMAGE_AREA_SUM_DEFINES_SVH
`define INTEGRAL_IMAGE_AREA_SUM_DEFINES_SVH

// check cons in the same cycle as ante
`define IIAS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante
`define IIAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/iias_pkg.sv =====
// ----------------------------------------------------------------------------
// Integral image area sum: shared package
// Field widths, register indexes, the reset size and the query state type.
// ----------------------------------------------------------------------------
package iias_pkg;

    localparam int SUM_W     = 22;
    localparam int ROW_SUM_W = 15;
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 7;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 8'd128;

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_READ,
        Q_DRAIN,
        Q_DONE
    } t_qstate;

endpackage

// ===== rtl/integral_image_area_sum.sv =====
// ----------------------------------------------------------------------------
// Integral image area sum: loads one pixel a cycle unless a query stalls it;
// table writes come from the registered s2 stage. A query holds the input in
// read (four reads, one read port), drain and done; a bad one skips to done.
// Reset clears positions, row sum, query control and sets both sizes to 128.
// ----------------------------------------------------------------------------
`include "integral_image_area_sum_defines.svh"

module integral_image_area_sum import iias_pkg::*; #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_func,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic [COORD_W-1:0]   i_min_col,
    input  logic [COORD_W-1:0]   i_min_row,
    input  logic [COORD_W-1:0]   i_max_col,
    input  logic [COORD_W-1:0]   i_max_row,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SUM_W-1:0]     o_area_sum,
    output logic                 o_bad_query
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCW_A = $clog2(MAX_WIDTH + 1);
    localparam int HCW_A = $clog2(MAX_HEIGHT + 1);
    localparam int WCW   = (WCW_A > CFG_W) ? WCW_A : CFG_W;
    localparam int HCW   = (HCW_A > CFG_W) ? HCW_A : CFG_W;

    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic [WCW-1:0]   eff_width;
    logic [HCW-1:0]   eff_height;

    logic             accept;
    logic             load_rd_en;
    logic [AW-1:0]    load_rd_addr;
    logic             load_wr_en;
    logic [AW-1:0]    load_wr_addr;
    logic [SUM_W-1:0] load_wr_data;
    logic             q_busy;
    logic             q_rd_en;
    logic [AW-1:0]    q_rd_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [SUM_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_DIM_RESET;
            r_cfg_height <= CFG_DIM_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            eff_width = WCW'(1);
        end else if (WCW'(r_cfg_width) > WCW'(MAX_WIDTH)) begin
            eff_width = WCW'(MAX_WIDTH);
        end else begin
            eff_width = WCW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            eff_height = HCW'(1);
        end else if (HCW'(r_cfg_height) > HCW'(MAX_HEIGHT)) begin
            eff_height = HCW'(MAX_HEIGHT);
        end else begin
            eff_height = HCW'(r_cfg_height);
        end
    end

    assign o_stall = q_busy;
    assign accept  = i_valid && !o_stall;
    assign rd_en   = load_rd_en || q_rd_en;
    assign rd_addr = q_busy ? q_rd_addr : load_rd_addr;

    iias_table #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (load_wr_en),
        .i_wr_addr(load_wr_addr),
        .i_wr_data(load_wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    iias_load #(
        .MAX_WIDTH(MAX_WIDTH),
        .AW       (AW),
        .CW       (CW),
        .RW       (RW),
        .WCW      (WCW),
        .HCW      (HCW)
    ) u_load (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && !i_func),
        .i_pixel     (i_pixel),
        .i_eff_width (eff_width),
        .i_eff_height(eff_height),
        .i_rd_data   (rd_data),
        .o_rd_en     (load_rd_en),
        .o_rd_addr   (load_rd_addr),
        .o_wr_en     (load_wr_en),
        .o_wr_addr   (load_wr_addr),
        .o_wr_data   (load_wr_data)
    );

    iias_query #(
        .MAX_WIDTH(MAX_WIDTH),
        .AW       (AW),
        .WCW      (WCW),
        .HCW      (HCW)
    ) u_query (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_query     (accept && i_func),
        .i_min_col   (i_min_col),
        .i_min_row   (i_min_row),
        .i_max_col   (i_max_col),
        .i_max_row   (i_max_row),
        .i_eff_width (eff_width),
        .i_eff_height(eff_height),
        .i_rd_data   (rd_data),
        .o_busy      (q_busy),
        .o_rd_en     (q_rd_en),
        .o_rd_addr   (q_rd_addr),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_area_sum  (o_area_sum),
        .o_bad_query (o_bad_query)
    );

    `IIAS_ASSERT_SAME(a_no_write_in_query, q_rd_en, !load_wr_en, "table write during query read")
    `IIAS_ASSERT_NEXT(a_query_holds_input, accept && i_func, o_stall, "input not held after query")
    `IIAS_ASSERT_SAME(a_out_after_query, $rose(o_valid), $past(q_busy), "result word without query")
    `IIAS_ASSERT_SAME(a_bad_is_zero, o_valid && o_bad_query, o_area_sum == '0, "bad query sum not zero")

endmodule

// ===== rtl/iias_table.sv =====
// ----------------------------------------------------------------------------
// Summed-area table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iias_table import iias_pkg::*; #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [SUM_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [SUM_W-1:0] o_rd_data
);

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/iias_load.sv =====
// ----------------------------------------------------------------------------
// Pixel load pipeline
// Tracks the raster position and row sum, reads the entry above and writes
// the new table entry in the following cycle, forwarding a same-entry write.
// ----------------------------------------------------------------------------
module iias_load import iias_pkg::*; #(
    parameter int MAX_WIDTH = 128,
    parameter int AW        = 14,
    parameter int CW        = 7,
    parameter int RW        = 7,
    parameter int WCW       = 8,
    parameter int HCW       = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic [WCW-1:0]   i_eff_width,
    input  logic [HCW-1:0]   i_eff_height,
    input  logic [SUM_W-1:0] i_rd_data,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [SUM_W-1:0] o_wr_data
);

    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    logic [ROW_SUM_W-1:0] r_row_sum;
    logic [CW-1:0]        n_col;
    logic [RW-1:0]        n_row;
    logic [ROW_SUM_W-1:0] n_row_sum;

    logic                 r_s2_vld;
    logic [AW-1:0]        r_s2_addr;
    logic [ROW_SUM_W-1:0] r_s2_sum;
    logic                 r_s2_above;
    logic                 r_fwd;
    logic [SUM_W-1:0]     r_fwd_data;

    logic [RW-1:0]        row_above;
    logic [WCW-1:0]       col_inc;
    logic [HCW-1:0]       row_inc;
    logic [SUM_W-1:0]     above_sum;

    assign row_above = r_row - 1'b1;
    assign col_inc   = WCW'(r_col) + 1'b1;
    assign row_inc   = HCW'(r_row) + 1'b1;

    assign n_row_sum = ((r_col == '0) ? '0 : r_row_sum) + ROW_SUM_W'(i_pixel);

    always_comb begin
        if (col_inc >= i_eff_width) begin
            n_col = '0;
            n_row = (row_inc >= i_eff_height) ? '0 : RW'(row_inc);
        end else begin
            n_col = CW'(col_inc);
            n_row = r_row;
        end
    end

    assign o_rd_en   = i_load && (r_row != '0);
    assign o_rd_addr = AW'(int'(row_above) * MAX_WIDTH + int'(r_col));

    assign above_sum = r_fwd ? r_fwd_data : i_rd_data;
    assign o_wr_en   = r_s2_vld;
    assign o_wr_addr = r_s2_addr;
    assign o_wr_data = SUM_W'(r_s2_sum) + (r_s2_above ? above_sum : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_row_sum <= '0;
            r_s2_vld  <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_s2_vld <= i_load;
            r_fwd    <= o_wr_en && o_rd_en && (o_wr_addr == o_rd_addr);
            if (i_load) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_row_sum <= n_row_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= o_wr_data;
        if (i_load) begin
            r_s2_addr  <= AW'(int'(r_row) * MAX_WIDTH + int'(r_col));
            r_s2_sum   <= n_row_sum;
            r_s2_above <= (r_row != '0);
        end
    end

endmodule

// ===== rtl/iias_query.sv =====
// ----------------------------------------------------------------------------
// Rectangle query sequencer
// Checks the rectangle, reads up to four corner entries through the shared
// read port, accumulates them and holds the result word in an output register.
// ----------------------------------------------------------------------------
module iias_query import iias_pkg::*; #(
    parameter int MAX_WIDTH = 128,
    parameter int AW        = 14,
    parameter int WCW       = 8,
    parameter int HCW       = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_query,
    input  logic [COORD_W-1:0] i_min_col,
    input  logic [COORD_W-1:0] i_min_row,
    input  logic [COORD_W-1:0] i_max_col,
    input  logic [COORD_W-1:0] i_max_row,
    input  logic [WCW-1:0]     i_eff_width,
    input  logic [HCW-1:0]     i_eff_height,
    input  logic [SUM_W-1:0]   i_rd_data,
    output logic               o_busy,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [SUM_W-1:0]   o_area_sum,
    output logic               o_bad_query
);

    localparam logic [1:0] TERM_CORNER = 2'd0;
    localparam logic [1:0] TERM_ABOVE  = 2'd1;
    localparam logic [1:0] TERM_LEFT   = 2'd2;
    localparam logic [1:0] TERM_DIAG   = 2'd3;

    t_qstate            r_state;
    t_qstate            n_state;
    logic [COORD_W-1:0] r_c0;
    logic [COORD_W-1:0] r_r0;
    logic [COORD_W-1:0] r_c1;
    logic [COORD_W-1:0] r_r1;
    logic [1:0]         r_term;
    logic               r_rd_vld;
    logic [1:0]         r_rd_term;
    logic [SUM_W-1:0]   r_acc;
    logic               r_bad;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_out_sum;
    logic               r_out_bad;

    logic               bad;
    logic               out_load;
    logic [COORD_W-1:0] rd_col;
    logic [COORD_W-1:0] rd_row;
    logic               term_use;

    assign bad = (i_min_col > i_max_col) || (i_min_row > i_max_row) ||
                 (WCW'(i_max_col) >= i_eff_width) ||
                 (HCW'(i_max_row) >= i_eff_height);

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        unique case (r_state)
            Q_IDLE: begin
                if (i_query) begin
                    n_state = bad ? Q_DONE : Q_READ;
                end
            end
            Q_READ: begin
                if (r_term == TERM_DIAG) begin
                    n_state = Q_DRAIN;
                end
            end
            Q_DRAIN: begin
                n_state = Q_DONE;
            end
            Q_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = Q_IDLE;
                end
            end
            default: begin
                n_state = Q_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_col = r_c1;
        rd_row = r_r1;
        case (r_term)
            TERM_CORNER: begin
                rd_col = r_c1;
                rd_row = r_r1;
            end
            TERM_ABOVE: begin
                rd_col = r_c1;
                rd_row = r_r0 - 1'b1;
            end
            TERM_LEFT: begin
                rd_col = r_c0 - 1'b1;
                rd_row = r_r1;
            end
            default: begin
                rd_col = r_c0 - 1'b1;
                rd_row = r_r0 - 1'b1;
            end
        endcase
    end

    always_comb begin
        case (r_rd_term)
            TERM_CORNER: term_use = 1'b1;
            TERM_ABOVE:  term_use = (r_r0 != '0);
            TERM_LEFT:   term_use = (r_c0 != '0);
            default:     term_use = (r_r0 != '0) && (r_c0 != '0);
        endcase
    end

    assign o_busy    = (r_state != Q_IDLE);
    assign o_rd_en   = (r_state == Q_READ);
    assign o_rd_addr = AW'(int'(rd_row) * MAX_WIDTH + int'(rd_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= Q_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= o_rd_en;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_term <= r_term;
        if (r_state == Q_IDLE) begin
            r_term <= TERM_CORNER;
        end else if (o_rd_en) begin
            r_term <= r_term + 1'b1;
        end
        if (r_state == Q_IDLE && i_query) begin
            r_c0  <= i_min_col;
            r_r0  <= i_min_row;
            r_c1  <= i_max_col;
            r_r1  <= i_max_row;
            r_bad <= bad;
            r_acc <= '0;
        end else if (r_rd_vld && term_use) begin
            if (r_rd_term == TERM_ABOVE || r_rd_term == TERM_LEFT) begin
                r_acc <= r_acc - i_rd_data;
            end else begin
                r_acc <= r_acc + i_rd_data;
            end
        end
        if (out_load) begin
            r_out_sum <= r_acc;
            r_out_bad <= r_bad;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_area_sum  = r_out_sum;
    assign o_bad_query = r_out_bad;

endmodule

// ===== test/tb_integral_image_area_sum.sv =====
// ----------------------------------------------------------------------------
// Integral image area sum: testbench
// Fills the whole table, then loads small, clamped and resized images and
// asks rectangle sums and bad queries against a summed-area table mirror.
// Both sides idle and stall at random; every result word is checked in order.
// ----------------------------------------------------------------------------
module tb_integral_image_area_sum import iias_pkg::*;;

    localparam int MAX_W       = 128;
    localparam int MAX_H       = 128;
    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] min_col;
        logic [COORD_W-1:0] min_row;
        logic [COORD_W-1:0] max_col;
        logic [COORD_W-1:0] max_row;
    } pix_word_t;

    typedef struct packed {
        logic [SUM_W-1:0] area_sum;
        logic             bad_query;
    } area_word_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_func;
    logic [PIX_W-1:0]     i_pixel;
    logic [COORD_W-1:0]   i_min_col;
    logic [COORD_W-1:0]   i_min_row;
    logic [COORD_W-1:0]   i_max_col;
    logic [COORD_W-1:0]   i_max_row;
    logic                 o_valid;
    logic                 i_stall;
    logic [SUM_W-1:0]     o_area_sum;
    logic                 o_bad_query;

    logic [SUM_W-1:0]     sat_mirror [MAX_W*MAX_H];
    logic [ROW_SUM_W-1:0] row_acc_mirror;
    int unsigned          load_col_mirror;
    int unsigned          load_row_mirror;
    logic [CFG_W-1:0]     width_reg_mirror;
    logic [CFG_W-1:0]     height_reg_mirror;

    area_word_t           pending_sums [$];
    area_word_t           head_sum;
    int unsigned          mismatches;
    int unsigned          words_sent;
    int unsigned          stuck_cycles;
    bit                   idle_on;

    integral_image_area_sum #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_pixel     (i_pixel),
        .i_min_col   (i_min_col),
        .i_min_row   (i_min_row),
        .i_max_col   (i_max_col),
        .i_max_row   (i_max_row),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_area_sum  (o_area_sum),
        .o_bad_query (o_bad_query)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned lim);
        if (v == '0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void integrate_word(pix_word_t w);
        int unsigned      col;
        int unsigned      row;
        int unsigned      wd;
        int unsigned      ht;
        int unsigned      c0;
        int unsigned      r0;
        int unsigned      c1;
        int unsigned      r1;
        logic [SUM_W-1:0] s;
        area_word_t       res;
        wd = clamp_dim(width_reg_mirror, MAX_W);
        ht = clamp_dim(height_reg_mirror, MAX_H);
        if (w.func == FUNC_LOAD) begin
            col = (load_col_mirror >= MAX_W) ? MAX_W - 1 : load_col_mirror;
            row = (load_row_mirror >= MAX_H) ? MAX_H - 1 : load_row_mirror;
            if (col == 0) row_acc_mirror = '0;
            row_acc_mirror = row_acc_mirror + ROW_SUM_W'(w.pixel);
            s = SUM_W'(row_acc_mirror);
            if (row > 0) s = s + sat_mirror[(row - 1) * MAX_W + col];
            sat_mirror[row * MAX_W + col] = s;
            if (col + 1 >= wd) begin
                load_col_mirror = 0;
                load_row_mirror = (row + 1 >= ht) ? 0 : row + 1;
            end else begin
                load_col_mirror = col + 1;
                load_row_mirror = row;
            end
        end else begin
            c0 = w.min_col;
            r0 = w.min_row;
            c1 = w.max_col;
            r1 = w.max_row;
            if (c0 > c1 || r0 > r1 || c1 >= wd || r1 >= ht) begin
                res.area_sum  = '0;
                res.bad_query = 1'b1;
            end else begin
                s = sat_mirror[r1 * MAX_W + c1];
                if (r0 != 0) s = s - sat_mirror[(r0 - 1) * MAX_W + c1];
                if (c0 != 0) s = s - sat_mirror[r1 * MAX_W + c0 - 1];
                if (r0 != 0 && c0 != 0) s = s + sat_mirror[(r0 - 1) * MAX_W + c0 - 1];
                res.area_sum  = s;
                res.bad_query = 1'b0;
            end
            pending_sums.push_back(res);
        end
    endfunction

    task automatic report_mismatch(string what, area_word_t want, area_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected sum %0d bad %0b, got sum %0d bad %0b",
                     what, want.area_sum, want.bad_query, got.area_sum, got.bad_query);
    endtask

    task automatic send_word(pix_word_t w);
        if (idle_on && $urandom_range(0, 99) < 23) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < 40) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= w.func;
        i_pixel   <= w.pixel;
        i_min_col <= w.min_col;
        i_min_row <= w.min_row;
        i_max_col <= w.max_col;
        i_max_row <= w.max_row;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        integrate_word(w);
        words_sent++;
    endtask

    task automatic send_load(logic [PIX_W-1:0] pix);
        pix_word_t w;
        w.func    = FUNC_LOAD;
        w.pixel   = pix;
        w.min_col = COORD_W'($urandom);
        w.min_row = COORD_W'($urandom);
        w.max_col = COORD_W'($urandom);
        w.max_row = COORD_W'($urandom);
        send_word(w);
    endtask

    task automatic send_query(int unsigned c0, int unsigned r0, int unsigned c1,
                              int unsigned r1);
        pix_word_t w;
        w.func    = FUNC_QUERY;
        w.pixel   = PIX_W'($urandom);
        w.min_col = COORD_W'(c0);
        w.min_row = COORD_W'(r0);
        w.max_col = COORD_W'(c1);
        w.max_row = COORD_W'(r1);
        send_word(w);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_random_query();
        int unsigned wd;
        int unsigned ht;
        int unsigned c0;
        int unsigned r0;
        int unsigned c1;
        int unsigned r1;
        wd = clamp_dim(width_reg_mirror, MAX_W);
        ht = clamp_dim(height_reg_mirror, MAX_H);
        if ($urandom_range(0, 99) < 15) begin
            send_query($urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 127), $urandom_range(0, 127));
        end else begin
            c1 = $urandom_range(0, wd - 1);
            r1 = $urandom_range(0, ht - 1);
            c0 = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, c1);
            r0 = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, r1);
            send_query(c0, r0, c1, r1);
        end
    endtask

    task automatic load_to_origin();
        while (load_col_mirror != 0 || load_row_mirror != 0) send_load(rand_pixel());
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_IMAGE_WIDTH) width_reg_mirror = data;
        else height_reg_mirror = data;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_size(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
        settle();
        write_reg(CFG_IMAGE_WIDTH, wv);
        write_reg(CFG_IMAGE_HEIGHT, hv);
    endtask

    task automatic test_full_frame();
        repeat (MAX_W * MAX_H) send_load('1);
        send_query(0, 0, 127, 127);
        send_query(0, 0, 0, 0);
        send_query(127, 127, 127, 127);
        send_query(0, 127, 127, 127);
        send_query(127, 0, 127, 127);
        send_query(5, 7, 90, 100);
        send_query(127, 0, 0, 127);
        send_query(0, 127, 127, 0);
        // wrap into a new frame and query the partly reloaded table
        send_load('0);
        send_query(0, 0, 0, 0);
        send_query(1, 0, 1, 0);
        send_query(0, 0, 127, 127);
    endtask

    task automatic test_small_image();
        int i;
        set_size(8'd4, 8'd3);
        load_to_origin();
        for (i = 0; i < 12; i++)
            send_load((i == 0) ? 8'd255 : (i == 5) ? 8'd0 : PIX_W'($urandom));
        send_query(0, 0, 3, 2);
        send_query(0, 0, 0, 0);
        send_query(3, 2, 3, 2);
        send_query(0, 1, 3, 2);
        send_query(1, 0, 2, 2);
        send_query(1, 1, 2, 1);
        send_query(2, 0, 1, 2);
        send_query(0, 2, 3, 1);
        send_query(0, 0, 4, 2);
        send_query(0, 0, 3, 3);
        send_query(127, 127, 127, 127);
    endtask

    task automatic test_size_limits();
        set_size(8'd0, 8'd255);
        send_query(0, 0, 0, 127);
        send_query(0, 0, 1, 0);
        repeat (3) send_load(rand_pixel());
        send_query(0, 0, 0, 127);
        set_size(8'd255, 8'd0);
        send_query(0, 0, 127, 0);
        send_query(0, 0, 0, 1);
        repeat (3) send_load(rand_pixel());
        send_query(64, 0, 127, 0);
    endtask

    task automatic test_geometry_change();
        set_size(8'd10, 8'd6);
        load_to_origin();
        repeat (37) send_load(rand_pixel());
        // load column now past the new width
        set_size(8'd5, 8'd6);
        repeat (2) send_load(rand_pixel());
        repeat (3) send_random_query();
        // load row now past the new height
        set_size(8'd5, 8'd2);
        repeat (5) send_load(rand_pixel());
        repeat (3) send_random_query();
    endtask

    task automatic test_random_traffic();
        int unsigned      stop_at;
        int unsigned      nq;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        stop_at = words_sent + 550;
        idle_on = 1'b0;
        while (words_sent < stop_at) begin
            if (words_sent + 370 > stop_at) idle_on = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    wv = $urandom_range(100, 128);
                    hv = $urandom_range(0, 1);
                end
                1: begin
                    wv = $urandom_range(0, 1);
                    hv = $urandom_range(100, 128);
                end
                2: begin
                    wv = $urandom_range(129, 255);
                    hv = $urandom_range(0, 1);
                end
                default: begin
                    wv = $urandom_range(1, 10);
                    hv = $urandom_range(1, 8);
                end
            endcase
            set_size(wv, hv);
            load_to_origin();
            repeat (clamp_dim(wv, MAX_W) * clamp_dim(hv, MAX_H)) send_load(rand_pixel());
            nq = $urandom_range(6, 20);
            repeat (nq) begin
                if ($urandom_range(0, 4) == 0) send_load(rand_pixel());
                else send_random_query();
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= idle_on && ($urandom_range(0, 99) < 23);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_sums.size() == 0) begin
                report_mismatch("no word expected", '0, {o_area_sum, o_bad_query});
            end else begin
                head_sum = pending_sums.pop_front();
                if (o_area_sum !== head_sum.area_sum || o_bad_query !== head_sum.bad_query)
                    report_mismatch("area word", head_sum, {o_area_sum, o_bad_query});
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = CFG_IMAGE_WIDTH;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_stall           = 1'b0;
        i_func            = FUNC_LOAD;
        i_pixel           = '0;
        i_min_col         = '0;
        i_min_row         = '0;
        i_max_col         = '0;
        i_max_row         = '0;
        mismatches        = 0;
        words_sent        = 0;
        stuck_cycles      = 0;
        idle_on           = 1'b1;
        row_acc_mirror    = '0;
        load_col_mirror   = 0;
        load_row_mirror   = 0;
        width_reg_mirror  = CFG_DIM_RESET;
        height_reg_mirror = CFG_DIM_RESET;
        for (int i = 0; i < MAX_W * MAX_H; i++) sat_mirror[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_frame();
        test_small_image();
        test_size_limits();
        test_geometry_change();
        test_random_traffic();

        settle();
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
